[rtl/core/compacting_receive_buffer_match_unit_macros.svh]
// assertion macros for the compacting receive buffer match unit
`ifndef COMPACTING_RECEIVE_BUFFER_MATCH_UNIT_MACROS_SVH
`define COMPACTING_RECEIVE_BUFFER_MATCH_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define CRBM_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CRBM_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) ante |-> cons) else $error(msg);
`define CRBM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define CRBM_ASSERT_ALWAYS(name, prop, msg)
`define CRBM_ASSERT_IMPL(name, ante, cons, msg)
`define CRBM_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

[rtl/core/crbm_pkg.sv]
// package with field types, operation codes and cell control for the receive buffer
package crbm_pkg;
	localparam int KIND_W = 3;
	localparam int SRC_PORT_W = 8;
	localparam int PAY_W = 64;
	localparam int IDX_W = 4;

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [SRC_PORT_W-1:0] src_t;
	typedef logic [PAY_W-1:0] pay_t;
	typedef logic [IDX_W-1:0] idx_t;

	localparam kind_t KIND_PUSH = 3'd0;
	localparam kind_t KIND_SRCH_SRC = 3'd1;
	localparam kind_t KIND_SRCH_ANY = 3'd2;
	localparam kind_t KIND_READ = 3'd3;
	localparam kind_t KIND_ERASE = 3'd4;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_NO_MATCH = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_SCAN = 2'd1,
		S_PICK = 2'd2,
		S_EXEC = 2'd3
	} state_t;

	typedef struct packed {
		logic wr;
		logic sh;
		logic scan;
		logic any;
		logic filled;
	} cell_ctl_t;
endpackage

[rtl/core/crbm_if.sv]
// request and response channel interfaces of the receive buffer
interface crbm_req_if;
	import crbm_pkg::*;
	logic valid;
	logic ready;
	kind_t kind;
	src_t msg_source;
	pay_t msg_payload;
	logic msg_valid;
	idx_t entry_index;
	modport source (output valid, kind, msg_source, msg_payload, msg_valid, entry_index,
		input ready);
	modport sink (input valid, kind, msg_source, msg_payload, msg_valid, entry_index,
		output ready);
endinterface

interface crbm_rsp_if;
	import crbm_pkg::*;
	logic valid;
	logic ready;
	status_t status;
	idx_t found_index;
	src_t entry_source;
	pay_t entry_payload;
	modport source (output valid, status, found_index, entry_source, entry_payload,
		input ready);
	modport sink (input valid, status, found_index, entry_source, entry_payload,
		output ready);
endinterface

[rtl/core/crbm_cell.sv]
// one buffer slot: holds an entry, loads on push, takes its neighbor on erase, flags a match
module crbm_cell #(
	parameter int PAYLOAD_BITS = 64,
	parameter int SRC_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input crbm_pkg::cell_ctl_t ctl,
	input logic [SRC_BITS-1:0] key,
	input logic [SRC_BITS-1:0] push_src,
	input logic [PAYLOAD_BITS-1:0] push_pay,
	input logic push_val,
	input logic [SRC_BITS-1:0] nxt_src,
	input logic [PAYLOAD_BITS-1:0] nxt_pay,
	input logic nxt_val,
	output logic [SRC_BITS-1:0] src,
	output logic [PAYLOAD_BITS-1:0] pay,
	output logic valid,
	output logic hit
);
	logic [SRC_BITS-1:0] src_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic valid_q;
	logic hit_q;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			src_q <= push_src;
			pay_q <= push_pay;
		end else if (ctl.sh) begin
			src_q <= nxt_src;
			pay_q <= nxt_pay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (ctl.wr) begin
				valid_q <= push_val;
			end else if (ctl.sh) begin
				valid_q <= nxt_val;
			end
			if (ctl.scan) begin
				hit_q <= valid_q && ctl.filled && (ctl.any || (src_q == key));
			end
		end
	end

	assign src = src_q;
	assign pay = pay_q;
	assign valid = valid_q;
	assign hit = hit_q;
endmodule

[rtl/core/crbm_pick.sv]
// lowest set hit across the cell row, registered
module crbm_pick #(
	parameter int DEPTH = 16,
	localparam int IW = $clog2(DEPTH)
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [DEPTH-1:0] hits,
	output logic found,
	output logic [IW-1:0] idx
);
	logic [IW-1:0] first;
	logic found_q;
	logic [IW-1:0] idx_q;

	always_comb begin
		first = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hits[i]) begin
				first = IW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (en) begin
			found_q <= |hits;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_q <= first;
		end
	end

	assign found = found_q;
	assign idx = idx_q;
endmodule

[rtl/core/compacting_receive_buffer_match_unit.sv]
// top level of the compacting receive buffer with source match
//
//  channel  role    carries
//  req      sink    kind, msg_source, msg_payload, msg_valid, entry_index
//  rsp      source  status, found_index, entry_source, entry_payload
//
// every transaction steps in order through accept, cell compare, lowest-hit pick and execute
// the pick is a find-first over DEPTH registered hit bits; one transaction is in work at a time
// push and erase update the cell row in the execute cycle, erase shifts all later cells at once
// a new request is taken while the previous response waits; execute holds until rsp is free
// reset clears valid marks, fill count and handshake state; slot contents stay undefined
module compacting_receive_buffer_match_unit #(
	parameter int DEPTH = 16,
	parameter int PAYLOAD_BITS = 64,
	parameter int RANK_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	crbm_req_if.sink req,
	crbm_rsp_if.source rsp
);
	import crbm_pkg::*;
	`include "compacting_receive_buffer_match_unit_macros.svh"

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int SRC_W = (RANK_BITS < SRC_PORT_W) ? RANK_BITS : SRC_PORT_W;

	state_t state_q, state_d;
	logic req_ready, scan_en, pick_en, commit;

	kind_t op_kind_q;
	logic [SRC_W-1:0] op_src_q;
	logic [PAYLOAD_BITS-1:0] op_pay_q;
	logic op_val_q;
	idx_t op_idx_q;

	logic [CW-1:0] fill_q;

	logic [SRC_W-1:0] cell_src [DEPTH];
	logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];
	logic [DEPTH-1:0] cell_valid;
	logic [DEPTH-1:0] hit_vec;
	logic [DEPTH-1:0] wr_vec;
	cell_ctl_t cell_ctl [DEPTH];

	logic pick_found;
	logic [IW-1:0] pick_idx;

	logic [IW-1:0] sel;
	logic [IW-1:0] rd_addr;
	logic [SRC_W-1:0] rd_src;
	logic [PAYLOAD_BITS-1:0] rd_pay;
	logic full, in_depth, idx_filled, is_search;
	logic push_ok, erase_ok;

	status_t res_status;
	idx_t res_idx;
	src_t res_src;
	pay_t res_pay;

	logic rsp_valid_q;
	status_t rsp_status_q;
	idx_t rsp_idx_q;
	src_t rsp_src_q;
	pay_t rsp_pay_q;

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: state_d = S_PICK;
			S_PICK: state_d = S_EXEC;
			S_EXEC: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		scan_en = 1'b0;
		pick_en = 1'b0;
		commit = 1'b0;
		case (state_q)
			S_IDLE: req_ready = 1'b1;
			S_SCAN: scan_en = 1'b1;
			S_PICK: pick_en = 1'b1;
			S_EXEC: commit = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req.ready = req_ready;

	// transaction capture
	always_ff @(posedge clk) begin
		if (req.valid && req_ready) begin
			op_kind_q <= req.kind;
			op_src_q <= req.msg_source[SRC_W-1:0];
			op_pay_q <= req.msg_payload[PAYLOAD_BITS-1:0];
			op_val_q <= req.msg_valid;
			op_idx_q <= req.entry_index;
		end
	end

	// decode and result
	assign sel = IW'(op_idx_q);
	assign is_search = (op_kind_q == KIND_SRCH_SRC) || (op_kind_q == KIND_SRCH_ANY);
	assign rd_addr = is_search ? pick_idx : sel;
	assign rd_src = cell_src[rd_addr];
	assign rd_pay = cell_pay[rd_addr];
	assign full = fill_q == CW'(DEPTH);
	assign in_depth = int'(op_idx_q) < DEPTH;
	assign idx_filled = int'(op_idx_q) < int'(fill_q);

	always_comb begin
		res_status = ST_OK;
		res_idx = '0;
		res_src = '0;
		res_pay = '0;
		push_ok = 1'b0;
		erase_ok = 1'b0;
		case (op_kind_q)
			KIND_PUSH: begin
				if (!full) begin
					push_ok = 1'b1;
					res_idx = IDX_W'(fill_q);
					res_src = SRC_PORT_W'(op_src_q);
					res_pay = PAY_W'(op_pay_q);
				end else begin
					res_status = ST_FULL;
				end
			end
			KIND_SRCH_SRC, KIND_SRCH_ANY: begin
				if (pick_found) begin
					res_idx = IDX_W'(pick_idx);
					res_src = SRC_PORT_W'(rd_src);
					res_pay = PAY_W'(rd_pay);
				end else begin
					res_status = ST_NO_MATCH;
				end
			end
			KIND_READ: begin
				res_idx = op_idx_q;
				if (in_depth) begin
					res_src = SRC_PORT_W'(rd_src);
					res_pay = PAY_W'(rd_pay);
				end else begin
					res_status = ST_RANGE;
				end
			end
			KIND_ERASE: begin
				res_idx = op_idx_q;
				if (idx_filled) begin
					erase_ok = 1'b1;
					res_src = SRC_PORT_W'(rd_src);
					res_pay = PAY_W'(rd_pay);
				end else begin
					res_status = ST_RANGE;
				end
			end
			default: ;
		endcase
	end

	// cell row control
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			wr_vec[i] = commit && push_ok && (CW'(i) == fill_q);
			cell_ctl[i].wr = wr_vec[i];
			cell_ctl[i].sh = commit && erase_ok && (IW'(i) >= sel);
			cell_ctl[i].scan = scan_en;
			cell_ctl[i].any = op_kind_q == KIND_SRCH_ANY;
			cell_ctl[i].filled = CW'(i) < fill_q;
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [SRC_W-1:0] nxt_src;
		logic [PAYLOAD_BITS-1:0] nxt_pay;
		logic nxt_val;

		if (g == DEPTH - 1) begin : g_tail
			assign nxt_src = cell_src[g];
			assign nxt_pay = cell_pay[g];
			assign nxt_val = 1'b0;
		end else begin : g_body
			assign nxt_src = cell_src[g+1];
			assign nxt_pay = cell_pay[g+1];
			assign nxt_val = cell_valid[g+1];
		end

		crbm_cell #(
			.PAYLOAD_BITS(PAYLOAD_BITS),
			.SRC_BITS(SRC_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(cell_ctl[g]),
			.key(op_src_q),
			.push_src(op_src_q),
			.push_pay(op_pay_q),
			.push_val(op_val_q),
			.nxt_src(nxt_src),
			.nxt_pay(nxt_pay),
			.nxt_val(nxt_val),
			.src(cell_src[g]),
			.pay(cell_pay[g]),
			.valid(cell_valid[g]),
			.hit(hit_vec[g])
		);
	end

	crbm_pick #(
		.DEPTH(DEPTH)
	) u_pick (
		.clk(clk),
		.arst_n(arst_n),
		.en(pick_en),
		.hits(hit_vec),
		.found(pick_found),
		.idx(pick_idx)
	);

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (commit && push_ok) begin
			fill_q <= fill_q + CW'(1);
		end else if (commit && erase_ok) begin
			fill_q <= fill_q - CW'(1);
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_status_q <= res_status;
			rsp_idx_q <= res_idx;
			rsp_src_q <= res_src;
			rsp_pay_q <= res_pay;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.found_index = rsp_idx_q;
	assign rsp.entry_source = rsp_src_q;
	assign rsp.entry_payload = rsp_pay_q;

	`CRBM_ASSERT_NEXT(a_push_grows, commit && push_ok, fill_q == $past(fill_q) + CW'(1), "fill count not advanced by push")
	`CRBM_ASSERT_NEXT(a_erase_shrinks, commit && erase_ok, fill_q == $past(fill_q) - CW'(1), "fill count not reduced by erase")
	`CRBM_ASSERT_ALWAYS(a_single_write, $onehot0(wr_vec), "push writes more than one cell")
	`CRBM_ASSERT_IMPL(a_hit_valid, (state_q == S_EXEC) && is_search && pick_found, cell_valid[pick_idx], "search picked an invalid cell")
endmodule
